@@ design/h264_rtp_fu_a_depacketizer_defines.svh @@
// ----------------------------------------------------------------------------
// H.264 RTP FU-A depacketizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef H264_RTP_FU_A_DEPACKETIZER_DEFINES_SVH
`define H264_RTP_FU_A_DEPACKETIZER_DEFINES_SVH

// Hold cond on every clock edge out of reset.
`define H264FU_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Hold cons in the same cycle as ante.
`define H264FU_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/h264fu_pkg.sv @@
// ----------------------------------------------------------------------------
// h264fu_pkg
// Constants, result kinds and the command word passed from front to back.
// ----------------------------------------------------------------------------
package h264fu_pkg;

    // Frame capacity in bytes and derived length width.
    localparam int unsigned FRAME_BYTES = 1048576;
    localparam int LEN_W = $clog2(FRAME_BYTES + 1);

    // Fixed field widths.
    localparam int OFF_W = 20;
    localparam int SEQ_W = 16;
    localparam int TS_W  = 32;

    // Command queue geometry (depth is a power of two).
    localparam int CMDQ_DEPTH = 8;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // NAL and FU field constants.
    localparam logic [4:0] NAL_TYPE_FU_A = 5'd28;
    localparam logic [7:0] IND_KEEP_MASK = 8'hE0;
    localparam logic [7:0] HDR_TYPE_MASK = 8'h1F;
    localparam int         FU_START_POS  = 7;
    localparam int         FU_END_POS    = 6;
    localparam logic [7:0] F_BIT         = 8'h80;

    // Start code lengths in bytes.
    localparam logic [2:0] CODE_NONE  = 3'd0;
    localparam logic [2:0] CODE_SHORT = 3'd3;
    localparam logic [2:0] CODE_LONG  = 3'd4;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_PATCH  = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    // Results of one input byte, in order: patch, appends, frame done.
    typedef struct packed {
        logic             patch_en;
        logic [7:0]       patch_val;
        logic [OFF_W-1:0] patch_pos;
        logic [2:0]       code_len;
        logic [2:0]       n_app;
        logic [7:0]       data_val;
        logic [OFF_W-1:0] base;
        logic             done_en;
        logic             done_ovf;
    } cmd_t;

endpackage

@@ design/h264fu_front.sv @@
// ----------------------------------------------------------------------------
// h264fu_front
// Accept payload bytes, track packet and fragment state, emit one command word.
// ----------------------------------------------------------------------------
`include "h264_rtp_fu_a_depacketizer_defines.svh"

module h264fu_front
    import h264fu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             cmdq_full,
    input  logic [7:0]       payload_byte,
    input  logic             first_of_packet,
    input  logic             last_of_packet,
    input  logic [SEQ_W-1:0] seq_number,
    input  logic [TS_W-1:0]  rtp_timestamp,
    input  logic             marker_bit,
    output logic             cmd_push,
    output cmd_t             cmd
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_COPY,
        MODE_FU_HDR,
        MODE_DISCARD
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [TS_W-1:0]  stamp_reg, stamp_next;
    logic [SEQ_W-1:0] prev_seq_reg, prev_seq_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [OFF_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic [7:0]       hdr_val_reg, hdr_val_next;
    logic             open_reg, open_next;
    logic             drop_reg, drop_next;
    logic [7:0]       ind_reg, ind_next;
    logic             ovf_reg, ovf_next;

    logic             accept;
    logic [2:0]       code_sel;
    logic [2:0]       code_len;
    logic [2:0]       count;
    logic [2:0]       n_app;
    logic             data_en;
    logic [7:0]       data_val;
    logic             do_patch;
    logic             do_end;
    logic             do_done;
    logic             new_stamp;
    logic             hdr_fits;
    logic [7:0]       hdr;
    logic             gap;
    logic             drop_eff;
    logic [LEN_W-1:0] room;
    logic             ovf_after;

    assign accept = push && !cmdq_full;

    always_comb
    begin
        mode_next     = mode_reg;
        stamp_next    = stamp_reg;
        prev_seq_next = prev_seq_reg;
        hdr_pos_next  = hdr_pos_reg;
        hdr_val_next  = hdr_val_reg;
        open_next     = open_reg;
        drop_next     = drop_reg;
        ind_next      = ind_reg;

        code_len = CODE_NONE;
        data_en  = 1'b0;
        data_val = payload_byte;
        do_patch = 1'b0;
        do_end   = 1'b0;
        do_done  = 1'b0;

        code_sel  = (len_reg == '0) ? CODE_LONG : CODE_SHORT;
        hdr_fits  = ({1'b0, len_reg} + (LEN_W+1)'(code_sel)) < (LEN_W+1)'(FRAME_BYTES);
        hdr       = (ind_reg & IND_KEEP_MASK) | (payload_byte & HDR_TYPE_MASK);
        gap       = (seq_number - SEQ_W'(1)) != prev_seq_reg;
        drop_eff  = drop_reg || gap;
        new_stamp = (rtp_timestamp != stamp_reg) && (len_reg != '0);

        priority if (first_of_packet)
        begin
            if (new_stamp)
            begin
                // Close the frame and skip this packet entirely.
                do_patch  = open_reg;
                do_done   = 1'b1;
                mode_next = MODE_IDLE;
            end
            else
            begin
                stamp_next = rtp_timestamp;
                if (payload_byte[4:0] == NAL_TYPE_FU_A)
                begin
                    ind_next  = payload_byte;
                    mode_next = MODE_FU_HDR;
                end
                else
                begin
                    do_patch  = open_reg;
                    open_next = 1'b0;
                    drop_next = 1'b0;
                    code_len  = code_sel;
                    data_en   = 1'b1;
                    mode_next = MODE_COPY;
                end
                do_end = last_of_packet;
            end
        end
        else if (mode_reg == MODE_IDLE)
        begin
            // Stray byte: drop.
        end
        else if (mode_reg == MODE_FU_HDR)
        begin
            if (payload_byte[FU_START_POS])
            begin
                do_patch = open_reg;
                code_len = code_sel;
                data_en  = 1'b1;
                data_val = hdr;
                if (hdr_fits)
                begin
                    open_next    = 1'b1;
                    drop_next    = 1'b0;
                    hdr_pos_next = OFF_W'(len_reg + LEN_W'(code_sel));
                    mode_next    = MODE_COPY;
                end
                else
                begin
                    open_next = 1'b0;
                    drop_next = 1'b1;
                    mode_next = MODE_DISCARD;
                end
            end
            else if (!open_reg)
            begin
                drop_next = 1'b1;
                mode_next = MODE_DISCARD;
            end
            else
            begin
                do_patch  = gap;
                drop_next = drop_eff;
                mode_next = drop_eff ? MODE_DISCARD : MODE_COPY;
                if (payload_byte[FU_END_POS])
                begin
                    open_next = 1'b0;
                    drop_next = 1'b0;
                end
            end
            do_end = last_of_packet;
        end
        else
        begin
            data_en = (mode_reg == MODE_COPY);
            do_end  = last_of_packet;
        end

        // The patch marks the stored header; a new FU header overrides it.
        if (do_patch)
        begin
            hdr_val_next = hdr_val_reg | F_BIT;
        end
        if (!first_of_packet && mode_reg == MODE_FU_HDR && payload_byte[FU_START_POS]
            && hdr_fits)
        begin
            hdr_val_next = hdr;
        end

        count     = code_len + {2'b00, data_en};
        room      = LEN_W'(FRAME_BYTES) - len_reg;
        n_app     = (room < LEN_W'(count)) ? room[2:0] : count;
        len_next  = len_reg + LEN_W'(n_app);
        ovf_after = ovf_reg || (n_app != count);
        ovf_next  = ovf_after;

        if (do_end)
        begin
            prev_seq_next = seq_number;
            mode_next     = MODE_IDLE;
            do_done       = do_done || marker_bit;
        end

        if (do_done)
        begin
            len_next  = '0;
            open_next = 1'b0;
            drop_next = 1'b0;
            ovf_next  = 1'b0;
        end

        cmd.patch_en  = do_patch;
        cmd.patch_val = hdr_val_reg | F_BIT;
        cmd.patch_pos = hdr_pos_reg;
        cmd.code_len  = code_len;
        cmd.n_app     = n_app;
        cmd.data_val  = data_val;
        cmd.base      = OFF_W'(len_reg);
        cmd.done_en   = do_done;
        cmd.done_ovf  = ovf_after;

        cmd_push = accept && (do_patch || (n_app != '0) || do_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            stamp_reg    <= '0;
            prev_seq_reg <= '0;
            len_reg      <= '0;
            hdr_pos_reg  <= '0;
            hdr_val_reg  <= '0;
            open_reg     <= 1'b0;
            drop_reg     <= 1'b0;
            ind_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            stamp_reg    <= stamp_next;
            prev_seq_reg <= prev_seq_next;
            len_reg      <= len_next;
            hdr_pos_reg  <= hdr_pos_next;
            hdr_val_reg  <= hdr_val_next;
            open_reg     <= open_next;
            drop_reg     <= drop_next;
            ind_reg      <= ind_next;
            ovf_reg      <= ovf_next;
        end
    end

    `H264FU_ASSERT_ALWAYS(a_len_cap, len_reg <= LEN_W'(FRAME_BYTES), "frame length past capacity")
    `H264FU_ASSERT_IMPLY(a_hdr_in_frame, open_reg, LEN_W'(hdr_pos_reg) < len_reg, "open header outside frame")

endmodule

@@ design/h264fu_cmdq.sv @@
// ----------------------------------------------------------------------------
// h264fu_cmdq
// Short command queue between the front and back sections.
// ----------------------------------------------------------------------------
`include "h264_rtp_fu_a_depacketizer_defines.svh"

module h264fu_cmdq
    import h264fu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign full    = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CMDQ_CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CMDQ_CNT_W'(1);
            end
        end
    end

    `H264FU_ASSERT_ALWAYS(a_cnt_range, count_reg <= CMDQ_CNT_W'(CMDQ_DEPTH), "queue count past depth")

endmodule

@@ design/h264fu_back.sv @@
// ----------------------------------------------------------------------------
// h264fu_back
// Expand each command word into result words into the output register, one per
// cycle while the receiver keeps popping.
// ----------------------------------------------------------------------------
`include "h264_rtp_fu_a_depacketizer_defines.svh"

module h264fu_back
    import h264fu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       kind,
    output logic [7:0]       byte_value,
    output logic [OFF_W-1:0] frame_offset,
    output logic             overflow,
    output logic             run_last
);

    logic [2:0]       idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic             ovf_reg, ovf_next;
    logic             last_reg, last_next;

    logic [2:0]       total;
    logic [2:0]       j;
    logic             is_patch;
    logic             is_app;
    logic             item_last;
    logic             pop_ok;
    logic             load;

    always_comb
    begin
        total     = {2'b00, cmd.patch_en} + cmd.n_app + {2'b00, cmd.done_en};
        j         = idx_reg - {2'b00, cmd.patch_en};
        is_patch  = cmd.patch_en && (idx_reg == '0);
        is_app    = !is_patch && (j < cmd.n_app);
        item_last = (idx_reg == total - 3'd1);
        pop_ok    = pop && out_valid_reg;
        load      = cmd_valid && (!out_valid_reg || pop_ok);
        cmd_pop   = load && item_last;

        priority if (is_patch)
        begin
            kind_next = KIND_PATCH;
            byte_next = cmd.patch_val;
            off_next  = cmd.patch_pos;
            ovf_next  = 1'b0;
        end
        else if (is_app)
        begin
            kind_next = KIND_APPEND;
            if (j < cmd.code_len)
            begin
                byte_next = (j == cmd.code_len - 3'd1) ? 8'd1 : 8'd0;
            end
            else
            begin
                byte_next = cmd.data_val;
            end
            off_next = cmd.base + OFF_W'(j);
            ovf_next = 1'b0;
        end
        else
        begin
            kind_next = KIND_DONE;
            byte_next = 8'd0;
            off_next  = '0;
            ovf_next  = cmd.done_ovf;
        end
        last_next = item_last;

        // Advance within the command; restart at its last result.
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = item_last ? 3'd0 : idx_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            off_reg  <= off_next;
            ovf_reg  <= ovf_next;
            last_reg <= last_next;
        end
    end

    assign empty        = !out_valid_reg;
    assign kind         = kind_reg;
    assign byte_value   = byte_reg;
    assign frame_offset = off_reg;
    assign overflow     = ovf_reg;
    assign run_last     = last_reg;

    `H264FU_ASSERT_IMPLY(a_cmd_nonempty, cmd_valid, total != 3'd0, "queued command with no results")
    `H264FU_ASSERT_IMPLY(a_idx_range, cmd_valid, idx_reg < total, "result index past command")

endmodule

@@ design/h264_rtp_fu_a_depacketizer.sv @@
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_depacketizer
// Rebuild an Annex-B H.264 frame from RTP payload bytes (single NAL and FU-A)
// and report it as append, header patch and frame complete result words.
// ----------------------------------------------------------------------------
//
//   channel  | handshake          | words
//   ---------+--------------------+---------------------------------------------
//   input    | push / full        | payload_byte, first_of_packet, last_of_packet,
//            |                    | seq_number, rtp_timestamp, marker_bit
//   result   | pop / empty        | kind, byte_value, frame_offset, overflow,
//            |                    | run_last
//
// Cycles: the front takes one input word per cycle while full is low and turns
// it into at most one command word; the back sends one result word per cycle
// from that command while pop keeps up. An input word causes 0 to 6 result
// words, so the result port sets the sustained rate: a plain payload byte
// (one result) passes at one per cycle; a start code or frame end adds more.
// Reset clears all packet, fragment and frame state (empty frame, idle).
// Stalls: an 8-deep command queue absorbs start-code bursts; full rises only
// when it fills, and the result register holds while pop stays low.
//
// Input-side behavior:
//   - a first byte with a new timestamp on a non-empty frame patches an open
//     fragment, completes the frame and skips that packet
//   - an FU-A header with the start bit emits a start code and the rebuilt
//     NAL header, whose offset is kept for a later patch
//   - a continuation after a sequence gap patches the header and drops the
//     rest of the fragment
//   - a marker on the last byte completes the frame
//   - bytes beyond FRAME_BYTES are dropped and flagged on frame complete
//
module h264_rtp_fu_a_depacketizer
    import h264fu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       payload_byte,
    input  logic             first_of_packet,
    input  logic             last_of_packet,
    input  logic [SEQ_W-1:0] seq_number,
    input  logic [TS_W-1:0]  rtp_timestamp,
    input  logic             marker_bit,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       kind,
    output logic [7:0]       byte_value,
    output logic [OFF_W-1:0] frame_offset,
    output logic             overflow,
    output logic             run_last
);

    // Front to queue.
    logic cmd_push;
    cmd_t cmd_in;

    // Queue to back.
    logic cmdq_empty;
    logic cmd_pop;
    cmd_t cmd_out;

    // Front: classify each byte, keep frame and fragment state.
    h264fu_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .cmdq_full       (full),
        .payload_byte    (payload_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .seq_number      (seq_number),
        .rtp_timestamp   (rtp_timestamp),
        .marker_bit      (marker_bit),
        .cmd_push        (cmd_push),
        .cmd             (cmd_in)
    );

    // Queue: decouple the two sides so each stalls on its own.
    h264fu_cmdq u_cmdq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmdq_empty)
    );

    // Back: expand commands into result words.
    h264fu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!cmdq_empty),
        .cmd          (cmd_out),
        .cmd_pop      (cmd_pop),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .byte_value   (byte_value),
        .frame_offset (frame_offset),
        .overflow     (overflow),
        .run_last     (run_last)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: H.264 RTP FU-A depacketizer
// Drives RTP payload words through the push/full side and checks every result
// word on the pop/empty side against an in-bench frame rebuilder. A directed
// pass covers the packet corner cases, then random frames run in four
// handshake phases.
// ----------------------------------------------------------------------------
module testbench;
    import h264fu_pkg::*;

    // Packet parsing state of the predictor.
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COPY    = 2'd1,
        MODE_FU_HDR  = 2'd2,
        MODE_DISCARD = 2'd3
    } pkt_mode_t;

    // Cycles with no word moving on either side before the run is abandoned.
    localparam int STALL_LIMIT  = 1000;
    // Cycles to keep watching the result side once nothing is expected.
    localparam int DRAIN_CYCLES = 32;
    // Input words per random phase.
    localparam int PHASE_WORDS  = 15;
    // Printed mismatch lines; the rest are only counted.
    localparam int MAX_PRINTS   = 20;

    // ------------------------------------------------------------------------
    // Frame scoreboard: rebuild the expected result words from each accepted
    // input word and match them in order against the words popped.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        typedef struct {
            kind_t            kind;
            logic [7:0]       value;
            logic [OFF_W-1:0] offset;
            logic             ovf;
            logic             last;
        } result_t;

        logic [TS_W-1:0]  stamp;
        logic [SEQ_W-1:0] prev_seq;
        logic [LEN_W-1:0] frame_len;
        logic [OFF_W-1:0] hdr_pos;
        logic [7:0]       hdr_val;
        logic             frag_open;
        logic             frag_drop;
        pkt_mode_t        mode;
        logic [7:0]       ind_byte;
        logic             ovf_seen;

        result_t expected_q[$];
        int      errors;
        int      results_seen;
        int      frames_seen;
        int      patches_seen;

        function new();
            stamp        = '0;
            prev_seq     = '0;
            frame_len    = '0;
            hdr_pos      = '0;
            hdr_val      = '0;
            frag_open    = 1'b0;
            frag_drop    = 1'b0;
            mode         = MODE_IDLE;
            ind_byte     = '0;
            ovf_seen     = 1'b0;
            errors       = 0;
            results_seen = 0;
            frames_seen  = 0;
            patches_seen = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add(kind_t k, logic [7:0] v, logic [OFF_W-1:0] off, logic ovf);
            result_t r;
            r.kind   = k;
            r.value  = v;
            r.offset = off;
            r.ovf    = ovf;
            r.last   = 1'b0;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function bit append_byte(logic [7:0] b);
            if (frame_len < FRAME_BYTES) begin
                add(KIND_APPEND, b, frame_len[OFF_W-1:0], 1'b0);
                frame_len++;
                return 1'b1;
            end
            ovf_seen = 1'b1;
            return 1'b0;
        endfunction

        function void start_code();
            if (frame_len == 0)
                void'(append_byte(8'h00));
            void'(append_byte(8'h00));
            void'(append_byte(8'h00));
            void'(append_byte(8'h01));
        endfunction

        function void patch_open();
            if (frag_open) begin
                hdr_val = hdr_val | F_BIT;
                add(KIND_PATCH, hdr_val, hdr_pos, 1'b0);
            end
        endfunction

        function void complete_frame();
            add(KIND_DONE, 8'h00, '0, ovf_seen);
            frame_len = '0;
            frag_open = 1'b0;
            frag_drop = 1'b0;
            ovf_seen  = 1'b0;
        endfunction

        function void end_packet(logic [SEQ_W-1:0] seq, logic mk);
            prev_seq = seq;
            if (mk)
                complete_frame();
            mode = MODE_IDLE;
        endfunction

        function void note_word(logic [7:0] b, logic first, logic last,
                                logic [SEQ_W-1:0] seq, logic [TS_W-1:0] ts, logic mk);
            int               before_n;
            logic [7:0]       hdr;
            logic [LEN_W-1:0] pos;
            logic [SEQ_W-1:0] seq_back;
            result_t          tail;
            before_n = expected_q.size();
            seq_back = seq - 16'd1;
            if (first) begin
                if (ts != stamp && frame_len != 0) begin
                    // New timestamp on a non-empty frame: close it, skip packet.
                    patch_open();
                    complete_frame();
                    mode = MODE_IDLE;
                end else begin
                    stamp = ts;
                    if (b[4:0] == NAL_TYPE_FU_A) begin
                        ind_byte = b;
                        mode     = MODE_FU_HDR;
                    end else begin
                        patch_open();
                        frag_open = 1'b0;
                        frag_drop = 1'b0;
                        start_code();
                        void'(append_byte(b));
                        mode = MODE_COPY;
                    end
                    if (last)
                        end_packet(seq, mk);
                end
            end else if (mode == MODE_IDLE) begin
                // Stray word outside a packet: drop it.
            end else if (mode == MODE_FU_HDR) begin
                if (b[FU_START_POS]) begin
                    hdr = (ind_byte & IND_KEEP_MASK) | (b & HDR_TYPE_MASK);
                    patch_open();
                    start_code();
                    pos = frame_len;
                    if (append_byte(hdr)) begin
                        frag_open = 1'b1;
                        frag_drop = 1'b0;
                        hdr_pos   = pos[OFF_W-1:0];
                        hdr_val   = hdr;
                        mode      = MODE_COPY;
                    end else begin
                        frag_open = 1'b0;
                        frag_drop = 1'b1;
                        mode      = MODE_DISCARD;
                    end
                end else if (!frag_open) begin
                    frag_drop = 1'b1;
                    mode      = MODE_DISCARD;
                end else begin
                    if (seq_back != prev_seq) begin
                        patch_open();
                        frag_drop = 1'b1;
                    end
                    mode = frag_drop ? MODE_DISCARD : MODE_COPY;
                    if (b[FU_END_POS]) begin
                        frag_open = 1'b0;
                        frag_drop = 1'b0;
                    end
                end
                if (last)
                    end_packet(seq, mk);
            end else begin
                if (mode == MODE_COPY)
                    void'(append_byte(b));
                if (last)
                    end_packet(seq, mk);
            end
            if (expected_q.size() > before_n) begin
                tail      = expected_q.pop_back();
                tail.last = 1'b1;
                expected_q.insert(expected_q.size(), tail);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic [1:0] k, logic [7:0] v, logic [OFF_W-1:0] off,
                          logic ovf, logic rl);
            result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing pending: kind %0d value %02h off %0d",
                                 k, v, off));
            end else begin
                want = expected_q.pop_front();
                results_seen++;
                if (want.kind == KIND_DONE)
                    frames_seen++;
                if (want.kind == KIND_PATCH)
                    patches_seen++;
                if (k !== want.kind || v !== want.value || off !== want.offset ||
                    ovf !== want.ovf || rl !== want.last)
                    report($sformatf({"result %0d: got kind %0d val %02h off %0d ovf %b ",
                                      "last %b, want kind %0d val %02h off %0d ovf %b last %b"},
                                     results_seen, k, v, off, ovf, rl, want.kind,
                                     want.value, want.offset, want.ovf, want.last));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic             clk             = 1'b0;
    logic             rst_n           = 1'b0;
    logic             push            = 1'b0;
    logic             full;
    logic [7:0]       payload_byte    = '0;
    logic             first_of_packet = 1'b0;
    logic             last_of_packet  = 1'b0;
    logic [SEQ_W-1:0] seq_number      = '0;
    logic [TS_W-1:0]  rtp_timestamp   = '0;
    logic             marker_bit      = 1'b0;
    logic             empty;
    logic             pop             = 1'b0;
    logic [1:0]       kind;
    logic [7:0]       byte_value;
    logic [OFF_W-1:0] frame_offset;
    logic             overflow;
    logic             run_last;

    frame_scoreboard sb = new();

    // Handshake pressure for the current phase, in percent of cycles.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    int               words_sent  = 0;
    int               stall_count = 0;
    logic [SEQ_W-1:0] next_seq    = '0;
    logic [TS_W-1:0]  frame_ts    = '0;
    logic [7:0]       pkt_q[$];

    h264_rtp_fu_a_depacketizer uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .payload_byte    (payload_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .seq_number      (seq_number),
        .rtp_timestamp   (rtp_timestamp),
        .marker_bit      (marker_bit),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .byte_value      (byte_value),
        .frame_offset    (frame_offset),
        .overflow        (overflow),
        .run_last        (run_last)
    );

    // 10 ns clock, first rising edge at 5 ns.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: decide pop once per cycle on the falling edge, so that the
    // value is settled well before the rising edge that samples it.
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= rx_stall_pct);

    // Monitor: both handshakes are judged on the values present just before
    // the rising edge. Note the input word first; its results can only show
    // up on a later edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                sb.note_word(payload_byte, first_of_packet, last_of_packet,
                             seq_number, rtp_timestamp, marker_bit);
            if (pop && !empty)
                sb.check_result(kind, byte_value, frame_offset, overflow, run_last);
        end
    end

    // Watchdog: count cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results still pending",
                     STALL_LIMIT, sb.pending());
            $display("h264_rtp_fu_a_depacketizer test failed");
            $finish;
        end
    end

    // Present one input word on the falling edge and hold it until an edge
    // accepts it. Idle cycles go in front of the word at the phase's rate.
    task automatic send_word(input logic [7:0] b, input logic first, input logic last,
                             input logic [SEQ_W-1:0] seq, input logic [TS_W-1:0] ts,
                             input logic mk);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push            <= 1'b1;
        payload_byte    <= b;
        first_of_packet <= first;
        last_of_packet  <= last;
        seq_number      <= seq;
        rtp_timestamp   <= ts;
        marker_bit      <= mk;
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_sent++;
    endtask

    // Send the bytes in pkt_q as one packet. The timestamp only counts on the
    // first byte and the marker only on the last, so fill the others with
    // noise. Leave close low to abandon the packet without a last byte.
    task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [TS_W-1:0] ts,
                               input logic mk, input logic close);
        int n;
        n = pkt_q.size();
        for (int i = 0; i < n; i++)
            send_word(pkt_q[i], i == 0, close && (i == n - 1), seq,
                      (i == 0) ? ts : 32'($urandom),
                      (i == n - 1) ? mk : 1'($urandom_range(1)));
    endtask

    // Corner cases, mostly one packet each, with no handshake pressure.
    task automatic run_directed();
        // Stray word right after reset, even with last and marker set: ignore.
        send_word(8'h5A, 1'b0, 1'b1, 16'h1234, 32'h0, 1'b1);
        // Single NAL opening the frame: long start code, then the bytes.
        pkt_q = '{8'h65, 8'hFF};
        send_packet(16'd100, 32'h0, 1'b0, 1'b1);
        // FU-A start: short start code and the rebuilt NAL header.
        pkt_q = '{8'h7C, 8'h85, 8'hAB};
        send_packet(16'd101, 32'h0, 1'b0, 1'b1);
        // Continuation after a lost packet: patch the header, drop the rest.
        pkt_q = '{8'h7C, 8'h05, 8'h11};
        send_packet(16'd103, 32'h0, 1'b0, 1'b1);
        // End fragment while still dropping: nothing appended, fragment closes.
        pkt_q = '{8'h7C, 8'h45, 8'h22};
        send_packet(16'd104, 32'h0, 1'b0, 1'b1);
        // FU indicator that is also the last byte: no FU header at all.
        pkt_q = '{8'hFC};
        send_packet(16'd105, 32'h0, 1'b0, 1'b1);
        // Start and end bits together: treated as a start, stays open.
        pkt_q = '{8'h5C, 8'hC1};
        send_packet(16'd106, 32'h0, 1'b0, 1'b1);
        // Single NAL while a fragment is open: patch the open header.
        pkt_q = '{8'h41};
        send_packet(16'd107, 32'h0, 1'b0, 1'b1);
        // FU start abandoned by a new packet before its last byte.
        pkt_q = '{8'h7C, 8'h81};
        send_packet(16'd108, 32'h0, 1'b0, 1'b0);
        // New timestamp on a non-empty frame: patch, complete, skip packet.
        pkt_q = '{8'h06, 8'h07};
        send_packet(16'd109, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // Empty frame adopts the timestamp; marker completes the frame.
        pkt_q = '{8'hFF};
        send_packet(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // Fragment across the sequence wrap, ended with the marker.
        pkt_q = '{8'h7C, 8'h9C};
        send_packet(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
        pkt_q = '{8'h7C, 8'h5C, 8'h00};
        send_packet(16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // Continuation with no fragment open, marker on an empty frame.
        pkt_q = '{8'h7C, 8'h01};
        send_packet(16'h0001, 32'hFFFF_FFFF, 1'b1, 1'b1);
    endtask

    // One random unit of traffic. Most of it is well-formed single NAL
    // packets and FU-A trains with random content; the rest is lost packets,
    // timestamp changes, stray words, abandoned packets and raw noise.
    task automatic send_random_unit();
        int         pick;
        int         frags;
        logic [7:0] ind;
        logic [7:0] hdr;
        logic [4:0] nal_type;
        logic       mk;
        pick = $urandom_range(99);
        if (pick < 30) begin
            pkt_q.delete();
            hdr = 8'($urandom);
            if (hdr[4:0] == NAL_TYPE_FU_A)
                hdr[0] = ~hdr[0];
            pkt_q.insert(pkt_q.size(), hdr);
            repeat ($urandom_range(3))
                pkt_q.insert(pkt_q.size(), 8'($urandom));
            mk = ($urandom_range(4) == 0);
            send_packet(next_seq, frame_ts, mk, 1'b1);
            next_seq++;
            if (mk && $urandom_range(1))
                frame_ts = 32'($urandom);
        end else if (pick < 75) begin
            ind      = {3'($urandom), NAL_TYPE_FU_A};
            nal_type = 5'($urandom);
            frags    = $urandom_range(4, 2);
            for (int i = 0; i < frags; i++) begin
                pkt_q.delete();
                pkt_q.insert(pkt_q.size(), ind);
                pkt_q.insert(pkt_q.size(),
                             {i == 0, i == frags - 1, 1'($urandom_range(1)), nal_type});
                repeat ($urandom_range(3))
                    pkt_q.insert(pkt_q.size(), 8'($urandom));
                // Lose a packet now and then.
                if ($urandom_range(9) == 0)
                    next_seq++;
                mk = (i == frags - 1) && ($urandom_range(2) == 0);
                send_packet(next_seq, frame_ts, mk, 1'b1);
                next_seq++;
            end
            if (mk && $urandom_range(1))
                frame_ts = 32'($urandom);
        end else if (pick < 85) begin
            frame_ts = 32'($urandom);
        end else if (pick < 90) begin
            send_word(8'($urandom), 1'b0, 1'($urandom_range(1)), 16'($urandom),
                      32'($urandom), 1'($urandom_range(1)));
        end else if (pick < 95) begin
            pkt_q.delete();
            pkt_q.insert(pkt_q.size(), $urandom_range(1) ? {3'($urandom), NAL_TYPE_FU_A}
                                                         : 8'($urandom));
            repeat ($urandom_range(2))
                pkt_q.insert(pkt_q.size(), 8'($urandom));
            send_packet(next_seq, frame_ts, 1'b0, 1'b0);
            next_seq++;
        end else begin
            send_word(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      16'($urandom), 32'($urandom), 1'($urandom_range(1)));
        end
    endtask

    // Main sequence.
    initial
    begin
        int unsigned tx_pct[4];
        int unsigned rx_pct[4];
        int          phase_base;
        tx_pct = '{0, 65, 0, 16};
        rx_pct = '{0, 0, 65, 16};

        // Hold reset, then release it on a falling edge.
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // Start the random sequence numbers close to the wrap.
        next_seq = 16'hFFFF - 16'($urandom_range(8));
        frame_ts = 32'($urandom);
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = tx_pct[p];
            rx_stall_pct = rx_pct[p];
            phase_base   = words_sent;
            while (words_sent - phase_base < PHASE_WORDS)
                send_random_unit();
        end

        // Stop pushing, let the receiver run freely and drain what is owed.
        @(negedge clk);
        push         <= 1'b0;
        rx_stall_pct  = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        // Keep watching for stray extra results.
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("sent %0d input words in directed and four random handshake phases",
                 words_sent);
        $display("checked %0d result words: %0d frames completed, %0d header patches",
                 sb.results_seen, sb.frames_seen, sb.patches_seen);
        if (sb.errors == 0)
            $display("h264_rtp_fu_a_depacketizer test passed");
        else
            $display("h264_rtp_fu_a_depacketizer test failed");
        $finish;
    end

endmodule
